// ===== sv/body_state_verlet_integrator_top_macros.svh =====
// ----------------------------------------------------------------------------
// body state verlet integrator assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef BODY_STATE_VERLET_INTEGRATOR_TOP_MACROS_SVH
`define BODY_STATE_VERLET_INTEGRATOR_TOP_MACROS_SVH

// same-cycle implication
`define BSVI_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSVI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bsvi_pkg.sv =====
// ----------------------------------------------------------------------------
// bsvi_pkg
// shared types, codes and constants of the body state verlet integrator
// ----------------------------------------------------------------------------
package bsvi_pkg;

	localparam int MAX_BODIES = 1024;
	localparam int VALUE_W    = 48;
	localparam int STEP_W     = 32;
	localparam int STEP_FRAC  = 24;
	localparam int IDX_W      = $clog2(MAX_BODIES);
	localparam int CNT_W      = $clog2(MAX_BODIES + 1);
	localparam int OP_W       = 3;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;

	// scaling datapath widths
	localparam int OPND_W = VALUE_W + 1;
	localparam int LO_W   = (OPND_W + 1) / 2;
	localparam int HI_W   = OPND_W - LO_W;
	localparam int PROD_W = OPND_W + STEP_W;
	localparam int SCL_W  = PROD_W - STEP_FRAC;
	localparam int SQ_W   = 2 * STEP_W;

	// opcodes
	localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
	localparam logic [OP_W-1:0] OP_POS_STEP = 3'd1;
	localparam logic [OP_W-1:0] OP_VEL_STEP = 3'd2;
	localparam logic [OP_W-1:0] OP_DRIFT    = 3'd3;
	localparam logic [OP_W-1:0] OP_READ     = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANAR_MODE = 1'd1;

	// reset values: dt = 1.0, dt/2 and dt^2/2 both 0.5
	localparam logic [STEP_W-1:0] STEP_RESET    = 32'h0100_0000;
	localparam logic [STEP_W-1:0] HALF_RESET    = 32'h0080_0000;
	localparam logic [STEP_W-1:0] HALF_SQ_RESET = 32'h0080_0000;

	typedef logic signed [VALUE_W-1:0] value_t;

	localparam value_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam value_t VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [IDX_W-1:0] body_index;
		value_t           vec_a_x;
		value_t           vec_a_y;
		value_t           vec_a_z;
		value_t           vec_b_x;
		value_t           vec_b_y;
		value_t           vec_b_z;
		logic             is_fixed;
	} cmd_t;

	typedef struct packed {
		value_t              out_pos_x;
		value_t              out_pos_y;
		value_t              out_pos_z;
		value_t              out_vel_x;
		value_t              out_vel_y;
		value_t              out_vel_z;
		logic                out_fixed;
		logic [CNT_W-1:0]    body_count;
		logic [STATUS_W-1:0] status;
		logic                saturated;
	} rsp_t;

	typedef struct packed {
		value_t pos_x;
		value_t pos_y;
		value_t pos_z;
		value_t vel_x;
		value_t vel_y;
		value_t vel_z;
		logic   fixed;
	} body_t;

	typedef struct packed {
		logic                      start;
		value_t                    base;
		logic signed [OPND_W-1:0]  operand;
		logic [STEP_W-1:0]         factor;
	} lane_req_t;

	typedef struct packed {
		logic   done;
		value_t result;
		logic   sat;
	} lane_rsp_t;

endpackage

// ===== sv/bsvi_body_ram.sv =====
// ----------------------------------------------------------------------------
// bsvi_body_ram
// body table: one entry per body, one write port, one registered read port
// ----------------------------------------------------------------------------
module bsvi_body_ram import bsvi_pkg::*; (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output body_t            rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  body_t            wr_data
);

	body_t mem_q [MAX_BODIES];
	body_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/bsvi_lane.sv =====
// ----------------------------------------------------------------------------
// bsvi_lane
// one vector component: base + clamp(operand * factor >> 24), saturating
// ----------------------------------------------------------------------------
module bsvi_lane import bsvi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lane_req_t req,
	output lane_rsp_t rsp
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic                    neg_s1, neg_s2, neg_s3;
	logic [OPND_W-1:0]       mag_s1;
	logic [STEP_W-1:0]       fac_s1;
	value_t                  base_s1, base_s2, base_s3, base_s4;
	logic [LO_W+STEP_W-1:0]  pp_lo_s2;
	logic [HI_W+STEP_W-1:0]  pp_hi_s2;
	logic [PROD_W-1:0]       prod_s3;
	value_t                  sc_s4;
	logic                    sat_s4;
	value_t                  res_s5;
	logic                    sat_s5;

	logic [OPND_W-1:0]  opnd_u;
	logic [SCL_W-1:0]   scl;
	logic [SCL_W-1:0]   lim;
	logic [VALUE_W-1:0] scl_low;
	logic               over;
	logic [VALUE_W:0]   sum_w;
	logic               ovf;

	assign opnd_u  = $unsigned(req.operand);
	assign scl     = prod_s3[PROD_W-1:STEP_FRAC];
	// negative side may reach one step further
	assign lim     = SCL_W'($unsigned(VAL_MAX)) + SCL_W'(neg_s3);
	assign over    = scl > lim;
	assign scl_low = scl[VALUE_W-1:0];
	assign sum_w   = {base_s4[VALUE_W-1], base_s4} + {sc_s4[VALUE_W-1], sc_s4};
	assign ovf     = sum_w[VALUE_W] != sum_w[VALUE_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		// magnitude and sign
		neg_s1  <= opnd_u[OPND_W-1];
		mag_s1  <= opnd_u[OPND_W-1] ? (~opnd_u + 1'b1) : opnd_u;
		fac_s1  <= req.factor;
		base_s1 <= req.base;
		// two partial products
		pp_lo_s2 <= mag_s1[LO_W-1:0] * fac_s1;
		pp_hi_s2 <= mag_s1[OPND_W-1:LO_W] * fac_s1;
		neg_s2   <= neg_s1;
		base_s2  <= base_s1;
		// full product
		prod_s3 <= PROD_W'(pp_lo_s2) + (PROD_W'(pp_hi_s2) << LO_W);
		neg_s3  <= neg_s2;
		base_s3 <= base_s2;
		// truncate toward zero, clamp, restore sign
		if (over) begin
			sc_s4 <= neg_s3 ? VAL_MIN : VAL_MAX;
		end else begin
			sc_s4 <= neg_s3 ? (~scl_low + 1'b1) : scl_low;
		end
		sat_s4  <= over;
		base_s4 <= base_s3;
		// saturating add
		if (ovf) begin
			res_s5 <= sum_w[VALUE_W] ? VAL_MIN : VAL_MAX;
		end else begin
			res_s5 <= sum_w[VALUE_W-1:0];
		end
		sat_s5 <= sat_s4 | ovf;
	end

	assign rsp.done   = v_s5;
	assign rsp.result = res_s5;
	assign rsp.sat    = sat_s5;

endmodule

// ===== sv/body_state_verlet_integrator_top.sv =====
// ----------------------------------------------------------------------------
// body_state_verlet_integrator_top
// fixed-point velocity verlet body table: one body per item, read-modify-write
// ----------------------------------------------------------------------------
//
// channel   dir   handshake               payload
// cmd       in    cmd_valid / cmd_stall   cmd   (cmd_t)
// rsp       out   rsp_valid / rsp_stall   rsp   (rsp_t)
// cfg       in    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// work per item: append, clear, errors and unused opcodes skip the body memory read
// and the lanes; read and fixed bodies take the read only; velocity step and drift
// add one 5-stage pass of the component lanes per scaled term, and position step
// takes two passes. a step_size write holds cmd_stall while dt^2/2 is derived.
// reset clears the body count and loads dt = 1.0; table entries are not cleared.
// a new item is taken while the previous result waits in the rsp register.
`include "body_state_verlet_integrator_top_macros.svh"

module body_state_verlet_integrator_top import bsvi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STEP_W-1:0]    cfg_data
);

	// sequencer states
	localparam int STATE_W = 3;
	localparam logic [STATE_W-1:0] S_IDLE    = 3'd0;
	localparam logic [STATE_W-1:0] S_READ    = 3'd1;
	localparam logic [STATE_W-1:0] S_START   = 3'd2;
	localparam logic [STATE_W-1:0] S_WAIT    = 3'd3;
	localparam logic [STATE_W-1:0] S_FINISH  = 3'd4;
	localparam logic [STATE_W-1:0] S_DELIVER = 3'd5;

	logic [STATE_W-1:0] state_q;
	logic [CNT_W-1:0]   count_q;
	logic               pass_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	rsp_t               res_q;
	cmd_t               cmd_q;
	body_t              work_q;
	logic               sat_q;

	// configuration and derived step factors
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] half_q;
	logic [STEP_W-1:0] half_sq_q;
	logic              planar_q;
	logic [1:0]        drv_cnt_q;
	logic [SQ_W-1:0]   sq_q;

	logic cmd_acc, cfg_acc, deliver_go;
	logic idx_ok, is_body_op, append_ok, needs_read;
	logic final_pass, wb_needed;
	rsp_t  res_imm, res_body;
	body_t work_nxt;
	logic  sat_nxt;

	// memory ports
	logic             ram_rd_en, ram_wr_en;
	logic [IDX_W-1:0] ram_rd_addr, ram_wr_addr;
	body_t            ram_rd_data, ram_wr_data, append_body;

	// lanes, one per component
	lane_req_t lreq [3];
	lane_rsp_t lrsp [3];
	value_t    wpos [3];
	value_t    wvel [3];
	value_t    va   [3];
	value_t    vb   [3];

	// ---------------------------------------------------------------- handshakes
	assign cmd_stall  = (state_q != S_IDLE) || (drv_cnt_q != 2'd0);
	assign cmd_acc    = cmd_valid && !cmd_stall;
	assign cfg_ready  = 1'b1;
	assign cfg_acc    = cfg_valid && cfg_ready;
	assign deliver_go = (state_q == S_DELIVER) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// ---------------------------------------------------------------- decode
	assign idx_ok     = CNT_W'(cmd.body_index) < count_q;
	assign is_body_op = (cmd.opcode == OP_POS_STEP) || (cmd.opcode == OP_VEL_STEP) ||
		(cmd.opcode == OP_DRIFT) || (cmd.opcode == OP_READ);
	assign append_ok  = (cmd.opcode == OP_APPEND) && (count_q != CNT_W'(MAX_BODIES));
	assign needs_read = is_body_op && idx_ok;

	assign append_body = '{pos_x: cmd.vec_a_x, pos_y: cmd.vec_a_y, pos_z: cmd.vec_a_z,
		vel_x: cmd.vec_b_x, vel_y: cmd.vec_b_y, vel_z: cmd.vec_b_z, fixed: cmd.is_fixed};

	// result of items that finish without touching a stored body
	always_comb begin
		res_imm            = '0;
		res_imm.body_count = count_q;
		res_imm.status     = ST_OK;
		case (cmd.opcode)
			OP_APPEND: begin
				if (!append_ok) begin
					res_imm.status = ST_FULL;
				end else begin
					res_imm.out_pos_x  = cmd.vec_a_x;
					res_imm.out_pos_y  = cmd.vec_a_y;
					res_imm.out_pos_z  = cmd.vec_a_z;
					res_imm.out_vel_x  = cmd.vec_b_x;
					res_imm.out_vel_y  = cmd.vec_b_y;
					res_imm.out_vel_z  = cmd.vec_b_z;
					res_imm.out_fixed  = cmd.is_fixed;
					res_imm.body_count = count_q + 1'b1;
				end
			end
			OP_CLEAR: begin
				res_imm.body_count = '0;
			end
			OP_POS_STEP, OP_VEL_STEP, OP_DRIFT, OP_READ: begin
				if (!idx_ok) begin
					res_imm.status = ST_BAD_INDEX;
				end
			end
			default: begin
				res_imm.status = ST_OK;
			end
		endcase
	end

	// result of items that addressed a stored body
	always_comb begin
		res_body            = '0;
		res_body.out_pos_x  = work_q.pos_x;
		res_body.out_pos_y  = work_q.pos_y;
		res_body.out_pos_z  = work_q.pos_z;
		res_body.out_vel_x  = work_q.vel_x;
		res_body.out_vel_y  = work_q.vel_y;
		res_body.out_vel_z  = work_q.vel_z;
		res_body.out_fixed  = work_q.fixed;
		res_body.body_count = count_q;
		res_body.status     = ST_OK;
		res_body.saturated  = sat_q;
	end

	// ---------------------------------------------------------------- lanes
	always_comb begin
		wpos[0] = work_q.pos_x;
		wpos[1] = work_q.pos_y;
		wpos[2] = work_q.pos_z;
		wvel[0] = work_q.vel_x;
		wvel[1] = work_q.vel_y;
		wvel[2] = work_q.vel_z;
		va[0]   = cmd_q.vec_a_x;
		va[1]   = cmd_q.vec_a_y;
		va[2]   = cmd_q.vec_a_z;
		vb[0]   = cmd_q.vec_b_x;
		vb[1]   = cmd_q.vec_b_y;
		vb[2]   = cmd_q.vec_b_z;
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lreq[k].start = (state_q == S_START);
			if (cmd_q.opcode == OP_VEL_STEP) begin
				// v += (a0 + a1) * dt/2, sum kept exact at one extra bit
				lreq[k].base    = wvel[k];
				lreq[k].operand = OPND_W'(va[k]) + OPND_W'(vb[k]);
				lreq[k].factor  = half_q;
			end else if ((cmd_q.opcode == OP_POS_STEP) && pass_q) begin
				// second term of the position step: a * dt^2/2
				lreq[k].base    = wpos[k];
				lreq[k].operand = OPND_W'(va[k]);
				lreq[k].factor  = half_sq_q;
			end else begin
				// p += v * dt
				lreq[k].base    = wpos[k];
				lreq[k].operand = OPND_W'(wvel[k]);
				lreq[k].factor  = step_q;
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		bsvi_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.req    (lreq[g]),
			.rsp    (lrsp[g])
		);
	end

	// fold lane results back into the working body
	assign final_pass = !((cmd_q.opcode == OP_POS_STEP) && !pass_q);
	// a zeroed planar z never counts as clamped
	assign sat_nxt = sat_q | lrsp[0].sat | lrsp[1].sat | (lrsp[2].sat & !planar_q);

	always_comb begin
		work_nxt = work_q;
		case (cmd_q.opcode)
			OP_VEL_STEP: begin
				work_nxt.vel_x = lrsp[0].result;
				work_nxt.vel_y = lrsp[1].result;
				work_nxt.vel_z = planar_q ? '0 : lrsp[2].result;
			end
			OP_POS_STEP: begin
				work_nxt.pos_x = lrsp[0].result;
				work_nxt.pos_y = lrsp[1].result;
				work_nxt.pos_z = (planar_q && final_pass) ? '0 : lrsp[2].result;
			end
			default: begin
				// drift also clears planar velocity z
				work_nxt.pos_x = lrsp[0].result;
				work_nxt.pos_y = lrsp[1].result;
				work_nxt.pos_z = planar_q ? '0 : lrsp[2].result;
				if (planar_q) begin
					work_nxt.vel_z = '0;
				end
			end
		endcase
	end

	// ---------------------------------------------------------------- body memory
	assign wb_needed   = (cmd_q.opcode != OP_READ) && !work_q.fixed;
	assign ram_rd_en   = cmd_acc && needs_read;
	assign ram_rd_addr = cmd.body_index;
	assign ram_wr_en   = (cmd_acc && append_ok) || ((state_q == S_FINISH) && wb_needed);
	assign ram_wr_addr = (state_q == S_FINISH) ? cmd_q.body_index : count_q[IDX_W-1:0];
	assign ram_wr_data = (state_q == S_FINISH) ? work_q : append_body;

	// reads only start in idle and writes back only in finish, so the
	// one-item-at-a-time sequencing keeps them from overlapping on an entry
	bsvi_body_ram u_ram (
		.clk     (clk),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pass_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one taken at this edge
			if (deliver_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						state_q <= needs_read ? S_READ : S_DELIVER;
						if (append_ok) begin
							count_q <= count_q + 1'b1;
						end else if (cmd.opcode == OP_CLEAR) begin
							count_q <= '0;
						end
					end
				end
				S_READ: begin
					pass_q <= 1'b0;
					// fixed bodies and reads skip the lanes
					if (ram_rd_data.fixed || (cmd_q.opcode == OP_READ)) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_START;
					end
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (lrsp[0].done) begin
						if (final_pass) begin
							state_q <= S_FINISH;
						end else begin
							pass_q  <= 1'b1;
							state_q <= S_START;
						end
					end
				end
				S_FINISH: begin
					state_q <= S_DELIVER;
				end
				S_DELIVER: begin
					if (deliver_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload and working body
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q <= cmd;
			res_q <= res_imm;
		end
		if (state_q == S_READ) begin
			work_q <= ram_rd_data;
			sat_q  <= 1'b0;
		end
		if ((state_q == S_WAIT) && lrsp[0].done) begin
			work_q <= work_nxt;
			sat_q  <= sat_nxt;
		end
		if (state_q == S_FINISH) begin
			res_q <= res_body;
		end
		if (deliver_go) begin
			rsp_q <= res_q;
		end
	end

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= STEP_RESET;
			half_q    <= HALF_RESET;
			half_sq_q <= HALF_SQ_RESET;
			planar_q  <= 1'b0;
			drv_cnt_q <= 2'd0;
		end else begin
			if (cfg_acc) begin
				case (cfg_index)
					REG_STEP_SIZE: begin
						step_q <= cfg_data;
					end
					REG_PLANAR_MODE: begin
						planar_q <= cfg_data[0];
					end
					default: begin
						planar_q <= planar_q;
					end
				endcase
			end
			// derive countdown restarts on every step_size write
			if (cfg_acc && (cfg_index == REG_STEP_SIZE)) begin
				drv_cnt_q <= 2'd2;
			end else if (drv_cnt_q != 2'd0) begin
				drv_cnt_q <= drv_cnt_q - 2'd1;
			end
			if (drv_cnt_q == 2'd2) begin
				half_q <= step_q >> 1;
			end
			// dt^2/2 = dt*dt >> 25, saturating to 32 bits
			if (drv_cnt_q == 2'd1) begin
				if (|sq_q[SQ_W-1:STEP_FRAC+1+STEP_W]) begin
					half_sq_q <= '1;
				end else begin
					half_sq_q <= sq_q[STEP_FRAC+STEP_W:STEP_FRAC+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drv_cnt_q == 2'd2) begin
			sq_q <= step_q * step_q;
		end
	end

	// ---------------------------------------------------------------- assertions
	`BSVI_ASSERT_IMPL(a_lane_done_in_wait, lrsp[0].done, state_q == S_WAIT, "lane result outside wait")
	`BSVI_ASSERT_IMPL(a_lanes_in_step, lrsp[0].done, lrsp[1].done && lrsp[2].done, "lanes out of step")
	`BSVI_ASSERT_IMPL(a_no_rw_overlap, ram_rd_en && ram_wr_en, ram_rd_addr != ram_wr_addr, "read and write hit one entry")
	`BSVI_ASSERT_NEXT(a_derive_blocks, cfg_acc && (cfg_index == REG_STEP_SIZE), cmd_stall, "item taken during step derive")
	`BSVI_ASSERT_IMPL(a_count_bound, state_q != S_READ, count_q <= CNT_W'(MAX_BODIES), "body count beyond table")

endmodule

// ===== sim/body_state_verlet_integrator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// body_state_verlet_integrator_top_tb
// self-checking bench: a short table of directed items, random phases under
// several dt and planar settings, and a table fill up to the full limit. each
// accepted item is run through a local fixed-point model of the body table and
// every result is compared field by field, in order, with its expectation
// ----------------------------------------------------------------------------
module body_state_verlet_integrator_top_tb;
	import bsvi_pkg::*;

	// opcodes the block leaves unused
	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	localparam value_t Q_ONE  = 48'sh0000_0100_0000;
	localparam value_t Q_HALF = 48'sh0000_0080_0000;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	cmd_t                 cmd = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [STEP_W-1:0]    cfg_data = '0;

	body_state_verlet_integrator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// body table model: its own copy of the table, the count and the config
	// ------------------------------------------------------------------------
	body_t             body_tab [MAX_BODIES];
	int unsigned       table_count = 0;
	logic [STEP_W-1:0] step_size;
	logic [STEP_W-1:0] half_step;
	logic [STEP_W-1:0] half_step_sq;
	bit                planar_on = 1'b0;
	bit                axis_clamped;

	// results still owed by the block, oldest first
	rsp_t body_reply_q [$];

	// directed table
	cmd_t dir_cmd [$];
	bit   dir_typed [$];
	rsp_t dir_rsp [$];

	int  fail_count = 0;
	int  shown = 0;
	int  rx_index = 0;
	bit  gaps_on = 1'b1;
	// set once the tail of the run starts: no idling on either side
	logic quiet_tail = 1'b0;

	// dt/2 and dt^2/2 are derived from dt on every write of the step register
	task automatic set_step(input logic [STEP_W-1:0] s);
		logic [63:0] sq;
		sq = ({32'd0, s} * {32'd0, s}) >> (STEP_FRAC + 1);
		step_size = s;
		half_step = s >> 1;
		half_step_sq = (sq > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : sq[31:0];
	endtask

	function automatic longint clamp_value(input longint v);
		if (v > longint'(VAL_MAX)) begin
			axis_clamped = 1'b1;
			return longint'(VAL_MAX);
		end
		if (v < longint'(VAL_MIN)) begin
			axis_clamped = 1'b1;
			return longint'(VAL_MIN);
		end
		return v;
	endfunction

	function automatic longint add_clamped(input longint a, input longint b);
		return clamp_value(a + b);
	endfunction

	// v * f >> 24, truncated toward zero, clamped to the value range
	function automatic longint scale_value(input longint v, input logic [STEP_W-1:0] f);
		logic [127:0] mag;
		logic [127:0] prod;
		bit           neg;
		neg = v < 0;
		mag = neg ? 128'(-v) : 128'(v);
		prod = (mag * {96'd0, f}) >> STEP_FRAC;
		if (neg) begin
			if (prod > 128'(VAL_MAX) + 128'd1) begin
				axis_clamped = 1'b1;
				return longint'(VAL_MIN);
			end
			return -longint'(prod[63:0]);
		end
		if (prod > 128'(VAL_MAX)) begin
			axis_clamped = 1'b1;
			return longint'(VAL_MAX);
		end
		return longint'(prod[63:0]);
	endfunction

	task automatic update_axis(input logic [OP_W-1:0] op, input bit zeroed,
		input longint a_in, input longint b_in,
		inout longint p, inout longint v, inout bit any_sat);
		axis_clamped = 1'b0;
		case (op)
			OP_POS_STEP: begin
				p = add_clamped(p, scale_value(v, step_size));
				p = add_clamped(p, scale_value(a_in, half_step_sq));
				if (zeroed)
					p = 0;
			end
			OP_VEL_STEP: begin
				v = add_clamped(v, scale_value(a_in + b_in, half_step));
				if (zeroed)
					v = 0;
			end
			default: begin
				p = add_clamped(p, scale_value(v, step_size));
				if (zeroed) begin
					p = 0;
					v = 0;
				end
			end
		endcase
		// a z that planar mode throws away does not count as clamped
		if (axis_clamped && !zeroed)
			any_sat = 1'b1;
	endtask

	task automatic predict_body(input cmd_t c, output rsp_t r);
		int unsigned         idx;
		logic [STATUS_W-1:0] st;
		bit                  has_body;
		bit                  any_sat;
		longint              p [3];
		longint              v [3];
		longint              a [3];
		longint              b [3];
		body_t               bd;
		idx = c.body_index;
		st = ST_OK;
		has_body = 1'b0;
		any_sat = 1'b0;
		r = '0;
		a[0] = c.vec_a_x;
		a[1] = c.vec_a_y;
		a[2] = c.vec_a_z;
		b[0] = c.vec_b_x;
		b[1] = c.vec_b_y;
		b[2] = c.vec_b_z;
		case (c.opcode)
			OP_APPEND: begin
				if (table_count >= MAX_BODIES) begin
					st = ST_FULL;
				end else begin
					idx = table_count;
					bd.pos_x = c.vec_a_x;
					bd.pos_y = c.vec_a_y;
					bd.pos_z = c.vec_a_z;
					bd.vel_x = c.vec_b_x;
					bd.vel_y = c.vec_b_y;
					bd.vel_z = c.vec_b_z;
					bd.fixed = c.is_fixed;
					body_tab[idx] = bd;
					table_count++;
					has_body = 1'b1;
				end
			end
			OP_POS_STEP, OP_VEL_STEP, OP_DRIFT, OP_READ: begin
				if (idx >= table_count) begin
					st = ST_BAD_INDEX;
				end else begin
					has_body = 1'b1;
					bd = body_tab[idx];
					// fixed bodies are handed back untouched
					if (c.opcode != OP_READ && !bd.fixed) begin
						p[0] = bd.pos_x;
						p[1] = bd.pos_y;
						p[2] = bd.pos_z;
						v[0] = bd.vel_x;
						v[1] = bd.vel_y;
						v[2] = bd.vel_z;
						for (int k = 0; k < 3; k++)
							update_axis(c.opcode, planar_on && k == 2, a[k], b[k],
								p[k], v[k], any_sat);
						bd.pos_x = value_t'(p[0]);
						bd.pos_y = value_t'(p[1]);
						bd.pos_z = value_t'(p[2]);
						bd.vel_x = value_t'(v[0]);
						bd.vel_y = value_t'(v[1]);
						bd.vel_z = value_t'(v[2]);
						body_tab[idx] = bd;
					end
				end
			end
			OP_CLEAR: table_count = 0;
			default: ;
		endcase
		if (has_body) begin
			bd = body_tab[idx];
			r.out_pos_x = bd.pos_x;
			r.out_pos_y = bd.pos_y;
			r.out_pos_z = bd.pos_z;
			r.out_vel_x = bd.vel_x;
			r.out_vel_y = bd.vel_y;
			r.out_vel_z = bd.vel_z;
			r.out_fixed = bd.fixed;
		end
		r.body_count = CNT_W'(table_count);
		r.status = st;
		r.saturated = has_body && any_sat;
	endtask

	// ------------------------------------------------------------------------
	// item builders
	// ------------------------------------------------------------------------
	function automatic cmd_t mk_cmd(input logic [OP_W-1:0] op, input int idx,
		input value_t ax, input value_t ay, input value_t az,
		input value_t bx, input value_t by, input value_t bz, input bit fx);
		cmd_t c;
		c.opcode = op;
		c.body_index = IDX_W'(idx);
		c.vec_a_x = ax;
		c.vec_a_y = ay;
		c.vec_a_z = az;
		c.vec_b_x = bx;
		c.vec_b_y = by;
		c.vec_b_z = bz;
		c.is_fixed = fx;
		return c;
	endfunction

	// the body as an append stores it
	function automatic rsp_t appended_rsp(input cmd_t c, input int cnt);
		rsp_t r;
		r.out_pos_x = c.vec_a_x;
		r.out_pos_y = c.vec_a_y;
		r.out_pos_z = c.vec_a_z;
		r.out_vel_x = c.vec_b_x;
		r.out_vel_y = c.vec_b_y;
		r.out_vel_z = c.vec_b_z;
		r.out_fixed = c.is_fixed;
		r.body_count = CNT_W'(cnt);
		r.status = ST_OK;
		r.saturated = 1'b0;
		return r;
	endfunction

	function automatic rsp_t bodiless_rsp(input int cnt, input logic [STATUS_W-1:0] st);
		rsp_t r;
		r = '0;
		r.body_count = CNT_W'(cnt);
		r.status = st;
		return r;
	endfunction

	function automatic value_t rand_value();
		case ($urandom_range(0, 9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2, 3, 4: return value_t'({$urandom, $urandom});
			5: return value_t'(int'($urandom_range(0, 255)) - 128);
			default: return value_t'(int'($urandom));
		endcase
	endfunction

	// mostly valid indexes so that steps land on stored bodies
	function automatic cmd_t rand_cmd();
		cmd_t c;
		int   pick;
		c.vec_a_x = rand_value();
		c.vec_a_y = rand_value();
		c.vec_a_z = rand_value();
		c.vec_b_x = rand_value();
		c.vec_b_y = rand_value();
		c.vec_b_z = rand_value();
		c.is_fixed = ($urandom_range(0, 6) == 0);
		c.body_index = IDX_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			c.opcode = OP_APPEND;
		end else if (pick < 90) begin
			if (pick < 45)
				c.opcode = OP_POS_STEP;
			else if (pick < 65)
				c.opcode = OP_VEL_STEP;
			else if (pick < 80)
				c.opcode = OP_DRIFT;
			else
				c.opcode = OP_READ;
			if (table_count != 0 && $urandom_range(0, 9) != 0)
				c.body_index = IDX_W'($urandom_range(0, table_count - 1));
		end else if (pick < 93) begin
			c.opcode = OP_CLEAR;
		end else if (pick < 96) begin
			c.opcode = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
		end else begin
			// raw index, usually past the end of the table
			c.opcode = OP_DRIFT;
		end
		return c;
	endfunction

	task automatic add_row(input cmd_t c, input bit typed, input rsp_t r);
		dir_cmd = {dir_cmd, c};
		dir_typed = {dir_typed, typed};
		dir_rsp = {dir_rsp, r};
	endtask

	// ------------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------------
	task automatic send_item(input cmd_t c, input bit typed, input rsp_t typed_rsp);
		rsp_t pred;
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		// accepted at this edge: the model moves on with it
		predict_body(c, pred);
		body_reply_q = {body_reply_q, (typed ? typed_rsp : pred)};
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
		end
	endtask

	// registers only change once every owed result is back
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (body_reply_q.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_STEP_SIZE)
			set_step(data);
		else
			planar_on = data[0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(input int n, input bit quiet);
		for (int i = 0; i < n; i++) begin
			// idle-free stretches now and then
			if (i % 40 == 0)
				gaps_on = !quiet && $urandom_range(0, 3) != 0;
			send_item(rand_cmd(), 1'b0, '0);
		end
	endtask

	initial begin
		cmd_t fast_body;
		cmd_t slow_body;
		cmd_t anchor_body;
		cmd_t last_body;
		cmd_t c;
		logic [STEP_W-1:0] dt;

		set_step(STEP_RESET);
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		// directed table, reset config: dt = 1.0, planar off
		fast_body = mk_cmd(OP_APPEND, 0, VAL_MAX, VAL_MIN, 0, VAL_MIN, VAL_MAX, Q_ONE, 1'b0);
		slow_body = mk_cmd(OP_APPEND, 1023, Q_ONE, 2 * Q_ONE, -3 * Q_ONE,
			Q_HALF, -Q_HALF, Q_ONE, 1'b0);
		anchor_body = mk_cmd(OP_APPEND, 0, 7 * Q_ONE, 8 * Q_ONE, 9 * Q_ONE,
			Q_ONE, Q_ONE, Q_ONE, 1'b1);
		last_body = mk_cmd(OP_APPEND, 5, -Q_HALF, VAL_MIN, VAL_MAX, 0, -1, 1, 1'b1);

		// empty table: every index is out of range
		add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, bodiless_rsp(0, ST_BAD_INDEX));
		add_row(mk_cmd(OP_POS_STEP, 5, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 1'b0), 1'b1,
			bodiless_rsp(0, ST_BAD_INDEX));
		add_row(fast_body, 1'b1, appended_rsp(fast_body, 1));
		add_row(slow_body, 1'b1, appended_rsp(slow_body, 2));
		add_row(anchor_body, 1'b1, appended_rsp(anchor_body, 3));
		// extreme values: saturating sums and products
		add_row(mk_cmd(OP_DRIFT, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0, '0);
		add_row(mk_cmd(OP_VEL_STEP, 0, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN, 0, 1'b0),
			1'b0, '0);
		add_row(mk_cmd(OP_POS_STEP, 0, VAL_MAX, VAL_MIN, Q_ONE, 0, 0, 0, 1'b0), 1'b0, '0);
		add_row(mk_cmd(OP_POS_STEP, 1, Q_ONE, -Q_ONE, Q_HALF, 0, 0, 0, 1'b0), 1'b0, '0);
		add_row(mk_cmd(OP_VEL_STEP, 1, Q_ONE, -Q_HALF, Q_ONE, Q_HALF, Q_HALF, -Q_ONE, 1'b0),
			1'b0, '0);
		add_row(mk_cmd(OP_DRIFT, 1, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0, '0);
		add_row(mk_cmd(OP_READ, 1, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0, '0);
		// fixed body: every update leaves it as appended
		add_row(mk_cmd(OP_POS_STEP, 2, VAL_MAX, VAL_MAX, VAL_MAX, 0, 0, 0, 1'b0), 1'b1,
			appended_rsp(anchor_body, 3));
		add_row(mk_cmd(OP_VEL_STEP, 2, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN,
			1'b0), 1'b1, appended_rsp(anchor_body, 3));
		add_row(mk_cmd(OP_DRIFT, 2, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, appended_rsp(anchor_body, 3));
		// index equal to the count, and the top index
		add_row(mk_cmd(OP_READ, 3, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, bodiless_rsp(3, ST_BAD_INDEX));
		add_row(mk_cmd(OP_VEL_STEP, 1023, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b0), 1'b1,
			bodiless_rsp(3, ST_BAD_INDEX));
		// unused opcodes change nothing
		add_row(mk_cmd(OP_SPARE_6, 0, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, 1'b1),
			1'b1, bodiless_rsp(3, ST_OK));
		add_row(mk_cmd(OP_SPARE_7, 1, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, 1'b1),
			1'b1, bodiless_rsp(3, ST_OK));
		add_row(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, bodiless_rsp(0, ST_OK));
		// append after clear lands at index 0 again
		add_row(last_body, 1'b1, appended_rsp(last_body, 1));
		add_row(mk_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, appended_rsp(last_body, 1));

		for (int i = 0; i < dir_cmd.size(); i++)
			send_item(dir_cmd[i], dir_typed[i], dir_rsp[i]);
		wait_idle();

		// random phases over several dt and planar settings, extremes first
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: dt = STEP_RESET;
				1: dt = 32'hFFFF_FFFF;
				2: dt = 32'h0000_0000;
				3: dt = 32'h0000_0001;
				4: dt = 32'h0040_0000;
				default: dt = $urandom;
			endcase
			write_reg(REG_STEP_SIZE, dt);
			write_reg(REG_PLANAR_MODE, STEP_W'(ph % 2));
			run_random(16, 1'b0);
			wait_idle();
		end

		// fill the table to the limit, then push against it
		write_reg(REG_STEP_SIZE, $urandom);
		write_reg(REG_PLANAR_MODE, STEP_W'(0));
		gaps_on = 1'b1;
		send_item(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0, '0);
		for (int i = 0; i < MAX_BODIES; i++) begin
			c = rand_cmd();
			c.opcode = OP_APPEND;
			send_item(c, 1'b0, '0);
			if (i % 100 == 99) begin
				c = rand_cmd();
				c.opcode = OP_POS_STEP;
				c.body_index = IDX_W'($urandom_range(0, table_count - 1));
				send_item(c, 1'b0, '0);
			end
		end
		// table full on append, then the top entry
		c = rand_cmd();
		c.opcode = OP_APPEND;
		send_item(c, 1'b0, '0);
		c = rand_cmd();
		c.body_index = IDX_W'(MAX_BODIES - 1);
		c.opcode = OP_POS_STEP;
		send_item(c, 1'b0, '0);
		c.opcode = OP_VEL_STEP;
		send_item(c, 1'b0, '0);
		c.opcode = OP_DRIFT;
		send_item(c, 1'b0, '0);
		c.opcode = OP_READ;
		send_item(c, 1'b0, '0);
		// receiver bursts stop here so none reaches into the tail
		quiet_tail <= 1'b1;
		wait_idle();

		// tail of the run: no idling anywhere
		write_reg(REG_STEP_SIZE, STEP_RESET);
		write_reg(REG_PLANAR_MODE, STEP_W'(1));
		run_random(48, 1'b1);
		wait_idle();
		repeat (30)
			@(posedge clk);

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// receiver side: random stall bursts, calm windows, and long hold-offs
	// that back the block up into its input
	// ------------------------------------------------------------------------
	int          hold_left = 0;
	int          burst_left = 0;
	int          rx_seen = 0;
	int unsigned rx_cycle = 0;

	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rsp_valid === 1'b1 && !rsp_stall)
			rx_seen <= rx_seen + 1;
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (rsp_valid === 1'b1 && !rsp_stall && (rx_seen == 400 || rx_seen == 800)) begin
			// sender keeps offering while this lasts
			rsp_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (burst_left != 0) begin
			rsp_stall <= 1'b1;
			burst_left <= burst_left - 1;
		end else if (!quiet_tail && !rx_cycle[8] && $urandom_range(0, 4) == 0) begin
			rsp_stall <= 1'b1;
			burst_left <= $urandom_range(0, 7);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// result checker
	// ------------------------------------------------------------------------
	task automatic note_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got)
			$display("  %s expected %h got %h", name, want, got);
	endtask

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && !rsp_stall) begin
			if (body_reply_q.size() == 0) begin
				fail_count++;
				if (shown < 10) begin
					shown++;
					$display("result %0d arrived with nothing owed: %h", rx_index, rsp);
				end
			end else begin
				want = body_reply_q.pop_front();
				if (rsp !== want) begin
					fail_count++;
					if (shown < 10) begin
						shown++;
						$display("result %0d mismatch", rx_index);
						note_field("out_pos_x", want.out_pos_x, rsp.out_pos_x);
						note_field("out_pos_y", want.out_pos_y, rsp.out_pos_y);
						note_field("out_pos_z", want.out_pos_z, rsp.out_pos_z);
						note_field("out_vel_x", want.out_vel_x, rsp.out_vel_x);
						note_field("out_vel_y", want.out_vel_y, rsp.out_vel_y);
						note_field("out_vel_z", want.out_vel_z, rsp.out_vel_z);
						note_field("out_fixed", want.out_fixed, rsp.out_fixed);
						note_field("body_count", want.body_count, rsp.body_count);
						note_field("status", want.status, rsp.status);
						note_field("saturated", want.saturated, rsp.saturated);
					end
				end
			end
			rx_index++;
		end
	end

	// watchdog
	int run_cycles = 0;

	always @(posedge clk) begin
		run_cycles <= run_cycles + 1;
		if (run_cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

endmodule

// ===== body_state_verlet_integrator_top.f =====
+incdir+sv
sv/bsvi_pkg.sv
sv/bsvi_body_ram.sv
sv/bsvi_lane.sv
sv/body_state_verlet_integrator_top.sv
sim/body_state_verlet_integrator_top_tb.sv
